/* design/assert_macros.svh */
// Assertion macros shared by the triangle pair packer modules.
// No dependencies; included by every file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, held off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* design/tpip_pkg.sv */
// Package for the triangle pair index packer: widths, payload structs,
// command format between front and back, and the record forming functions.
// No dependencies.
package tpip_pkg;

  localparam int IDX_W    = 16;
  // Command queue depth, power of two
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0][IDX_W-1:0] tri_t;
  typedef logic [1:0] sel_t;

  localparam sel_t SEL_0 = 2'd0;
  localparam sel_t SEL_1 = 2'd1;
  localparam sel_t SEL_2 = 2'd2;

  typedef struct packed {
    idx_t vert_first;
    idx_t vert_second;
    idx_t vert_third;
    logic final_tri;
  } item_t;

  typedef struct packed {
    idx_t idx_a;
    idx_t idx_b;
    idx_t idx_c;
    idx_t idx_d;
    logic is_pair;
    logic run_end;
    logic stream_end;
  } result_t;

  // What the back end has to emit for one input
  typedef enum logic [1:0] {
    OP_PAIR      = 2'd0,  // pending + incoming leave as one pair record
    OP_SINGLE_P  = 2'd1,  // pending leaves single, incoming is held
    OP_SINGLE_PT = 2'd2,  // pending single, then incoming single
    OP_SINGLE_T  = 2'd3   // incoming leaves single
  } op_t;

  typedef struct packed {
    op_t  op;
    sel_t edge_p;   // shared edge starts at this vertex of the pending triangle
    sel_t edge_t;   // reversed edge starts at this vertex of the incoming one
    logic fin;
    tri_t pend;
    tri_t inc;
  } cmd_t;

  // Rotate so that vertex k comes first
  function automatic tri_t rot3(tri_t v, sel_t k);
    tri_t r;
    case (k)
      SEL_1: begin
        r[0] = v[1];
        r[1] = v[2];
        r[2] = v[0];
      end
      SEL_2: begin
        r[0] = v[2];
        r[1] = v[0];
        r[2] = v[1];
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

  // Single triangle rotated so that the first index is at least the second
  function automatic result_t single_res(tri_t v);
    result_t r;
    r = '0;
    if (v[0] >= v[1]) begin
      r.idx_a = v[0];
      r.idx_b = v[1];
      r.idx_c = v[2];
    end else if (v[1] >= v[2]) begin
      r.idx_a = v[1];
      r.idx_b = v[2];
      r.idx_c = v[0];
    end else begin
      r.idx_a = v[2];
      r.idx_b = v[0];
      r.idx_c = v[1];
    end
    return r;
  endfunction

  // Pair record: shared edge smaller first, opposite vertices follow
  function automatic result_t pair_res(tri_t p, tri_t t, sel_t ep, sel_t et);
    result_t r;
    tri_t    pr;
    tri_t    tr;
    r  = '0;
    pr = rot3(p, ep);
    tr = rot3(t, et);
    r.is_pair = 1'b1;
    if (pr[0] < pr[1]) begin
      r.idx_a = pr[0];
      r.idx_b = pr[1];
      r.idx_c = pr[2];
      r.idx_d = tr[2];
    end else begin
      r.idx_a = pr[1];
      r.idx_b = pr[0];
      r.idx_c = tr[2];
      r.idx_d = pr[2];
    end
    return r;
  endfunction

endpackage

/* design/tpip_front.sv */
// Front end: accepts triangles, holds the pending one, finds the shared edge
// and pushes one command per input that produces output. Uses tpip_pkg.
`include "assert_macros.svh"
module tpip_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tpip_pkg::item_t   item,
  input  logic              cq_full,
  output logic              cmd_push,
  output tpip_pkg::cmd_t    cmd
);

  logic           pending_valid;
  tpip_pkg::tri_t pending_tri;
  logic           accept;
  tpip_pkg::tri_t tri_in;
  logic           degen;
  logic           match;
  tpip_pkg::sel_t mp;
  tpip_pkg::sel_t mt;
  logic           store;

  assign full   = cq_full;
  assign accept = push && !cq_full;

  assign tri_in[0] = item.vert_first;
  assign tri_in[1] = item.vert_second;
  assign tri_in[2] = item.vert_third;

  assign degen = (tri_in[0] == tri_in[1]) || (tri_in[1] == tri_in[2]) ||
                 (tri_in[2] == tri_in[0]);

  // Shared edge search: pending edges in order, incoming edges in order,
  // first reversed match wins
  always_comb begin
    match = 1'b0;
    mp    = tpip_pkg::SEL_0;
    mt    = tpip_pkg::SEL_0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!match &&
            tri_in[j] == pending_tri[(i == 2) ? 0 : i + 1] &&
            tri_in[(j == 2) ? 0 : j + 1] == pending_tri[i]) begin
          match = 1'b1;
          mp    = tpip_pkg::sel_t'(i);
          mt    = tpip_pkg::sel_t'(j);
        end
      end
    end
  end

  // Classification of the accepted triangle
  always_comb begin
    cmd.edge_p = mp;
    cmd.edge_t = mt;
    cmd.fin    = item.final_tri;
    cmd.pend   = pending_tri;
    cmd.inc    = tri_in;
    cmd.op     = tpip_pkg::OP_SINGLE_T;
    store      = 1'b0;
    cmd_push   = 1'b0;
    if (pending_valid) begin
      cmd_push = accept;
      if (match) begin
        cmd.op = tpip_pkg::OP_PAIR;
      end else if (item.final_tri || degen) begin
        cmd.op = tpip_pkg::OP_SINGLE_PT;
      end else begin
        cmd.op = tpip_pkg::OP_SINGLE_P;
        store  = 1'b1;
      end
    end else if (item.final_tri || degen) begin
      cmd.op   = tpip_pkg::OP_SINGLE_T;
      cmd_push = accept;
    end else begin
      store = 1'b1;
    end
  end

  // Pending triangle register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (accept) begin
      pending_valid <= store;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      pending_tri <= tri_in;
    end
  end

  `ASSERT_IMPL(a_push_on_accept, clk, rst, cmd_push, accept,
               "command pushed without a transfer")
  `ASSERT_IMPL(a_pair_needs_pending, clk, rst,
               cmd_push && cmd.op == tpip_pkg::OP_PAIR, pending_valid,
               "pair without pending triangle")

endmodule

/* design/tpip_cmd_fifo.sv */
// Short command queue between front and back ends.
// Uses tpip_pkg for the command type and depth.
`include "assert_macros.svh"
module tpip_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  tpip_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output logic           nonempty,
  output tpip_pkg::cmd_t rd_data
);

  tpip_pkg::cmd_t                    mem [tpip_pkg::CQ_DEPTH];
  logic [tpip_pkg::CQ_PTR_W-1:0]     wr_ptr;
  logic [tpip_pkg::CQ_PTR_W-1:0]     rd_ptr;
  logic [tpip_pkg::CQ_CNT_W-1:0]     count;

  assign full     = (count == tpip_pkg::CQ_CNT_W'(tpip_pkg::CQ_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, wr && full, "write into full command queue")
  `ASSERT_NEVER(a_no_underflow, clk, rst, rd && !nonempty, "read from empty command queue")

endmodule

/* design/tpip_back.sv */
// Back end: turns queued commands into result records, one per cycle while the output
// stage is empty or being popped, into a registered output stage. Uses tpip_pkg.
`include "assert_macros.svh"
module tpip_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  tpip_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output tpip_pkg::result_t   result
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_t;

  phase_t            phase;
  logic              out_valid;
  logic              load;
  logic              last;
  tpip_pkg::result_t res_next;

  assign empty = !out_valid;
  assign load  = cmd_valid && (!out_valid || pop);

  // Record forming for the command at the queue head
  always_comb begin
    last     = 1'b1;
    res_next = tpip_pkg::single_res(cmd.inc);
    case (cmd.op)
      tpip_pkg::OP_PAIR: begin
        res_next = tpip_pkg::pair_res(cmd.pend, cmd.inc, cmd.edge_p, cmd.edge_t);
      end
      tpip_pkg::OP_SINGLE_P: begin
        res_next = tpip_pkg::single_res(cmd.pend);
      end
      tpip_pkg::OP_SINGLE_PT: begin
        if (phase == PH_FIRST) begin
          res_next = tpip_pkg::single_res(cmd.pend);
          last     = 1'b0;
        end
      end
      default: begin
        res_next = tpip_pkg::single_res(cmd.inc);
      end
    endcase
    res_next.run_end    = last;
    res_next.stream_end = last && cmd.fin;
  end

  assign cmd_pop = load && last;

  // Output register and phase of a two-record command
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_FIRST;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= last ? PH_FIRST : PH_SECOND;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

  `ASSERT_IMPL(a_second_phase_head, clk, rst, phase == PH_SECOND,
               cmd_valid && cmd.op == tpip_pkg::OP_SINGLE_PT,
               "second record without a two-record command")
  `ASSERT_IMPL(a_pair_ordered, clk, rst, out_valid && result.is_pair,
               result.idx_a < result.idx_b, "pair record edge not ordered")

endmodule

/* design/triangle_pair_index_packer_core.sv */
// Triangle pair index packer: accepts one triangle per cycle while full is low.
// A result passes through the command queue and then the registered output stage.
// The back end emits one record per cycle while its output stage is empty or popped,
// so the queue absorbs the extra record of an input that produces two records.
// Reset (rst, synchronous): clears the pending triangle, queue and output stage.
// Depends on tpip_pkg, tpip_front, tpip_cmd_fifo, tpip_back.
module triangle_pair_index_packer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tpip_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output tpip_pkg::result_t   result
);

  logic           cq_full;
  logic           cq_wr;
  tpip_pkg::cmd_t cq_wr_data;
  logic           cq_rd;
  logic           cq_nonempty;
  tpip_pkg::cmd_t cq_rd_data;

  tpip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cq_full  (cq_full),
    .cmd_push (cq_wr),
    .cmd      (cq_wr_data)
  );

  tpip_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (cq_wr),
    .wr_data  (cq_wr_data),
    .full     (cq_full),
    .rd       (cq_rd),
    .nonempty (cq_nonempty),
    .rd_data  (cq_rd_data)
  );

  tpip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cq_nonempty),
    .cmd       (cq_rd_data),
    .cmd_pop   (cq_rd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
